>>> sv/b64u_pkg.sv
// ---------------------------------------------------------------------------
// b64u_pkg: shared types and constants of the base64url decoder
// Alphabet lookup, character codes and the sextet lookup function.
// ---------------------------------------------------------------------------
package b64u_pkg;

  // Character codes
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChPad    = 8'h3D;

  // Sextet values where the alphabet ranges start
  localparam logic [5:0] SxLowerBase = 6'd26;
  localparam logic [5:0] SxDigitBase = 6'd52;
  localparam logic [5:0] SxMinus     = 6'd62;
  localparam logic [5:0] SxUscore    = 6'd63;

  localparam int unsigned GroupBytes = 3;

  typedef struct packed {
    logic       hit;
    logic [5:0] val;
  } sextet_t;

  // Map one character to its sextet; hit is low outside the alphabet
  function automatic sextet_t sextet_lookup(input logic [7:0] ch);
    sextet_t r;
    r.hit = 1'b1;
    r.val = 6'd0;
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      r.val = 6'(ch - ChUpperA);
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      r.val = 6'(ch - ChLowerA) + SxLowerBase;
    end else if (ch >= ChDigit0 && ch <= ChDigit9) begin
      r.val = 6'(ch - ChDigit0) + SxDigitBase;
    end else if (ch == ChMinus) begin
      r.val = SxMinus;
    end else if (ch == ChUscore) begin
      r.val = SxUscore;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/base64url_decoder_top.sv
// ---------------------------------------------------------------------------
// base64url_decoder_top: streaming base64url decoder
// Takes one text character per word and gives decoded bytes, one per word.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one character and an
//   end-of-input flag per word. Output channel (out_valid_o/out_ready_i)
//   carries one decoded byte per word, with data_valid_o, last_of_run_o
//   (last word caused by that character) and stream_done_o (last word of
//   the stream). An end word with nothing left gives one word with
//   data_valid_o low.
//   A character passes the input register and then the result register
//   before its first result reaches the port. Throughput: one character
//   per cycle while the result register is free; a character that completes
//   a group holds it until its bytes drain, so input runs at the drain pace.
//   The rate is set by the single result register and its byte counter.
//   Characters that give no result pass even while the result register
//   is still draining.
//   Reset clears the decode state, the input stage and the result stage.
//   When the receiver stalls, the result register holds its word, one more
//   character waits in the input register, and in_ready_o then drops.
// ---------------------------------------------------------------------------
module base64url_decoder_top
  import b64u_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       data_valid_o,
  output logic       last_of_run_o,
  output logic       stream_done_o
);

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;

  // Decode state
  logic [17:0] buf_q, buf_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pad_q, pad_d;

  // Result register
  logic       g_valid_q, g_valid_d;
  logic [7:0] g_byte_q [GroupBytes];
  logic [1:0] g_cnt_q;
  logic [1:0] g_idx_q, g_idx_d;
  logic       g_dv_q;
  logic       g_done_q;

  // Decode outputs
  sextet_t    sx;
  logic [23:0] word;
  logic [7:0] res_byte [GroupBytes];
  logic [1:0] res_n;
  logic       res_dv;
  logic       res_done;

  logic       in_fire, out_fire, g_last, grp_free, s1_move;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign g_last   = (g_idx_q == g_cnt_q - 2'd1);
  assign grp_free = !g_valid_q || (out_ready_i && g_last);
  assign s1_move  = s1_valid_q && ((res_n == 2'd0) || grp_free);
  assign in_ready_o = !s1_valid_q || s1_move;

  // Decode one character against the current state
  always_comb begin
    sx       = sextet_lookup(s1_byte_q);
    word     = {buf_q, sx.val};
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    pad_d    = pad_q;
    res_n    = 2'd0;
    res_dv   = 1'b1;
    res_done = 1'b0;
    for (int i = 0; i < GroupBytes; i++) begin
      res_byte[i] = 8'd0;
    end
    if (!pad_q) begin
      if (s1_byte_q == ChPad) begin
        pad_d = 1'b1;
      end else if (sx.hit) begin
        if (cnt_q == 2'd3) begin
          res_byte[0] = word[23:16];
          res_byte[1] = word[15:8];
          res_byte[2] = word[7:0];
          res_n       = 2'd3;
          buf_d       = 18'd0;
          cnt_d       = 2'd0;
        end else begin
          buf_d = {buf_q[11:0], sx.val};
          cnt_d = cnt_q + 2'd1;
        end
      end
    end
    // Flush leftover sextets on the end word
    if (s1_end_q) begin
      case (cnt_d)
        2'd2: begin
          res_byte[0] = buf_d[11:4];
          res_n       = 2'd1;
        end
        2'd3: begin
          res_byte[0] = buf_d[17:10];
          res_byte[1] = buf_d[9:2];
          res_n       = 2'd2;
        end
        default: ;
      endcase
      if (res_n == 2'd0) begin
        res_n  = 2'd1;
        res_dv = 1'b0;
      end
      res_done = 1'b1;
      buf_d    = 18'd0;
      cnt_d    = 2'd0;
      pad_d    = 1'b0;
    end
  end

  // Input stage control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  // Result stage control
  always_comb begin
    g_valid_d = g_valid_q;
    g_idx_d   = g_idx_q;
    if (s1_move && res_n != 2'd0) begin
      g_valid_d = 1'b1;
      g_idx_d   = 2'd0;
    end else if (out_fire) begin
      if (g_last) begin
        g_valid_d = 1'b0;
      end else begin
        g_idx_d = g_idx_q + 2'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      g_valid_q  <= 1'b0;
      g_idx_q    <= 2'd0;
      buf_q      <= 18'd0;
      cnt_q      <= 2'd0;
      pad_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      g_valid_q  <= g_valid_d;
      g_idx_q    <= g_idx_d;
      if (s1_move) begin
        buf_q <= buf_d;
        cnt_q <= cnt_d;
        pad_q <= pad_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_end_q  <= end_of_input_i;
    end
    if (s1_move && res_n != 2'd0) begin
      for (int i = 0; i < GroupBytes; i++) begin
        g_byte_q[i] <= res_byte[i];
      end
      g_cnt_q  <= res_n;
      g_dv_q   <= res_dv;
      g_done_q <= res_done;
    end
  end

  // Drive the output word
  assign out_valid_o   = g_valid_q;
  assign data_byte_o   = g_byte_q[g_idx_q];
  assign data_valid_o  = g_dv_q;
  assign last_of_run_o = g_last;
  assign stream_done_o = g_done_q && g_last;

  // Assertions
  a_grp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_valid_q |-> (g_cnt_q != 2'd0) && (g_idx_q < g_cnt_q))
    else $error("result group count or index out of range");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> last_of_run_o)
    else $error("stream_done without last_of_run");

  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_valid_o) |-> (stream_done_o && data_byte_o == 8'd0))
    else $error("empty word that is not a clean end marker");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_end_q) |=> (cnt_q == 2'd0) && !pad_q && (buf_q == 18'd0))
    else $error("decode state not cleared after end word");

endmodule
